>>> sv/sem_pkg.sv
package sem_pkg;

	localparam int DEF_MAX_WIDTH = 64;
	localparam int PIXEL_W = 8;
	localparam int COL_W = 7;
	localparam int ROW_W = 8;
	localparam int LEVEL_W = 4;
	localparam int SUM_W = PIXEL_W + 2;
	localparam int MAG_W = SUM_W + 1;
	localparam int LEVEL_SHIFT = 7;
	localparam int MIN_SIZE = 3;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [COL_W-1:0] WIDTH_RESET = COL_W'(16);
	localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(16);

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               frame_start;
	} sem_pixel_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] edge_level;
		logic               row_end;
		logic               frame_end;
	} sem_result_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] top;
		logic [PIXEL_W-1:0] mid;
		logic [PIXEL_W-1:0] bot;
	} sem_column_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic             produce;
		logic             last_col;
		logic             last_row;
	} sem_pos_t;

endpackage

>>> sv/sem_ram.sv
module sem_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> sv/sem_scan.sv
module sem_scan #(
	parameter int MAX_WIDTH = sem_pkg::DEF_MAX_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sem_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [sem_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               advance,
	input  logic                               frame_start,
	output sem_pkg::sem_pos_t                  pos
);

	localparam int COL_MAX = 2 ** sem_pkg::COL_W - 1;
	localparam int WCAP = (MAX_WIDTH < COL_MAX) ? MAX_WIDTH : COL_MAX;

	logic [sem_pkg::COL_W-1:0] width_q;
	logic [sem_pkg::ROW_W-1:0] height_q;
	logic [sem_pkg::COL_W-1:0] col_q;
	logic [sem_pkg::ROW_W-1:0] row_q;

	logic [sem_pkg::COL_W-1:0] eff_w;
	logic [sem_pkg::ROW_W-1:0] eff_h;
	logic [sem_pkg::COL_W-1:0] col;
	logic [sem_pkg::ROW_W-1:0] row;
	logic [sem_pkg::COL_W-1:0] col_next;
	logic [sem_pkg::ROW_W-1:0] row_next;

	always_comb begin
		if (width_q < sem_pkg::COL_W'(sem_pkg::MIN_SIZE)) begin
			eff_w = sem_pkg::COL_W'(sem_pkg::MIN_SIZE);
		end else if (width_q > sem_pkg::COL_W'(WCAP)) begin
			eff_w = sem_pkg::COL_W'(WCAP);
		end else begin
			eff_w = width_q;
		end
		if (height_q < sem_pkg::ROW_W'(sem_pkg::MIN_SIZE)) begin
			eff_h = sem_pkg::ROW_W'(sem_pkg::MIN_SIZE);
		end else begin
			eff_h = height_q;
		end

		col = frame_start ? '0 : col_q;
		row = frame_start ? '0 : row_q;
		if (col >= eff_w) begin
			col = '0;
			row = row + 1'b1;
		end
		if (row >= eff_h) begin
			row = '0;
		end

		pos.col = col;
		pos.last_col = (col == eff_w - 1'b1);
		pos.last_row = (row == eff_h - 1'b1);
		pos.produce = (col >= sem_pkg::COL_W'(2)) && (row >= sem_pkg::ROW_W'(2));

		if (pos.last_col) begin
			col_next = '0;
			row_next = pos.last_row ? '0 : row + 1'b1;
		end else begin
			col_next = col + 1'b1;
			row_next = row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= sem_pkg::WIDTH_RESET;
			height_q <= sem_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sem_pkg::REG_FRAME_WIDTH: width_q <= cfg_data[sem_pkg::COL_W-1:0];
				sem_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data[sem_pkg::ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			col_q <= col_next;
			row_q <= row_next;
		end
	end

endmodule

>>> sv/sem_gradient.sv
module sem_gradient (
	input  sem_pkg::sem_column_t              left,
	input  sem_pkg::sem_column_t              center,
	input  sem_pkg::sem_column_t              right,
	output logic [sem_pkg::LEVEL_W-1:0]       edge_level
);

	localparam int SW = sem_pkg::SUM_W;
	localparam int MW = sem_pkg::MAG_W;

	function automatic logic [SW-1:0] weigh(
		input logic [sem_pkg::PIXEL_W-1:0] a,
		input logic [sem_pkg::PIXEL_W-1:0] b,
		input logic [sem_pkg::PIXEL_W-1:0] c
	);
		return SW'(a) + SW'({b, 1'b0}) + SW'(c);
	endfunction

	function automatic logic [SW-1:0] abs_diff(
		input logic [SW-1:0] p,
		input logic [SW-1:0] n
	);
		logic signed [SW:0] d;
		d = $signed({1'b0, p}) - $signed({1'b0, n});
		return d[SW] ? SW'(-d) : d[SW-1:0];
	endfunction

	logic [SW-1:0] gx_abs;
	logic [SW-1:0] gy_abs;
	logic [MW-1:0] mag;

	always_comb begin
		gx_abs = abs_diff(weigh(right.top, right.mid, right.bot),
			weigh(left.top, left.mid, left.bot));
		gy_abs = abs_diff(weigh(left.bot, center.bot, right.bot),
			weigh(left.top, center.top, right.top));
		mag = MW'(gx_abs) + MW'(gy_abs);
		edge_level = mag[sem_pkg::LEVEL_SHIFT +: sem_pkg::LEVEL_W];
	end

endmodule

>>> sv/sobel_edge_magnitude_3x3.sv
// Sobel 3x3 edge magnitude over a raster stream of 8-bit grayscale pixels.
// Pixel channel: pix_valid / pix_stall with payload pix (pixel, frame_start).
// A transaction happens at a rising edge with pix_valid high and pix_stall low.
// frame_start restarts the row and column count; the count also wraps on its
// own after the last pixel of a frame.
// Result channel: res_valid / res_stall with payload res (edge_level, row_end,
// frame_end). One result per pixel at column >= 2 and row >= 2, so a W x H
// frame gives (W-2) x (H-2) results; other pixels give none.
// Config channel: cfg_valid / cfg_ready, cfg_index 0 = frame_width,
// 1 = frame_height. cfg_ready is always high; write only while idle.
// Pipeline: a taken pixel is registered in the input stage (s1); when that
// stage advances, its result is loaded into the output register res.
// Throughput: one pixel per cycle while pix_stall is low; the single
// line-buffer RAM is read when the pixel is taken and written when the input stage advances.
// Reset: width and height return to 16, position to row 0 column 0, all
// pipeline and output valids clear. Line-buffer contents are not cleared.
// Stall: a held result blocks a following result; pix_stall rises only when
// the input stage holds a result that cannot move into the output register.
module sobel_edge_magnitude_3x3 #(
	parameter int MAX_WIDTH = sem_pkg::DEF_MAX_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pix_valid,
	output logic                               pix_stall,
	input  sem_pkg::sem_pixel_t                pix,
	output logic                               res_valid,
	input  logic                               res_stall,
	output sem_pkg::sem_result_t               res,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sem_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [sem_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int PW = sem_pkg::PIXEL_W;
	localparam int LW = 2 * PW;

	logic                  pix_accept;
	logic                  adv_s1;
	sem_pkg::sem_pos_t     pos;

	logic                  valid_s1;
	logic [PW-1:0]         pixel_s1;
	logic [AW-1:0]         addr_s1;
	logic                  produce_s1;
	logic                  last_col_s1;
	logic                  last_row_s1;
	logic                  byp_s1;
	logic [LW-1:0]         byp_data_s1;

	logic [AW-1:0]         rd_addr;
	logic [LW-1:0]         ram_rd;
	logic [LW-1:0]         lines;
	logic [LW-1:0]         wr_data;

	sem_pkg::sem_column_t  left_q;
	sem_pkg::sem_column_t  center_q;
	sem_pkg::sem_column_t  right_col;
	logic [sem_pkg::LEVEL_W-1:0] level;

	logic                  res_valid_q;
	sem_pkg::sem_result_t  res_q;

	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res = res_q;

	assign adv_s1 = valid_s1 && (!produce_s1 || !res_valid_q || !res_stall);
	assign pix_stall = valid_s1 && !adv_s1;
	assign pix_accept = pix_valid && !pix_stall;

	sem_scan #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.advance(pix_accept),
		.frame_start(pix.frame_start),
		.pos(pos)
	);

	assign rd_addr = AW'(pos.col);

	sem_ram #(
		.WIDTH(LW),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk(clk),
		.wr_en(adv_s1),
		.wr_addr(addr_s1),
		.wr_data(wr_data),
		.rd_en(pix_accept),
		.rd_addr(rd_addr),
		.rd_data(ram_rd)
	);

	// upper row in the high byte, middle row in the low byte
	assign lines = byp_s1 ? byp_data_s1 : ram_rd;
	assign wr_data = {lines[PW-1:0], pixel_s1};

	assign right_col.top = lines[LW-1:PW];
	assign right_col.mid = lines[PW-1:0];
	assign right_col.bot = pixel_s1;

	sem_gradient u_gradient (
		.left(left_q),
		.center(center_q),
		.right(right_col),
		.edge_level(level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// forward the line data being written when the new pixel reads the same column
	always_ff @(posedge clk) begin
		if (pix_accept) begin
			pixel_s1 <= pix.pixel;
			addr_s1 <= rd_addr;
			produce_s1 <= pos.produce;
			last_col_s1 <= pos.last_col;
			last_row_s1 <= pos.last_row;
			byp_s1 <= adv_s1 && (addr_s1 == rd_addr);
			byp_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			center_q <= '0;
		end else if (adv_s1) begin
			left_q <= center_q;
			center_q <= right_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && produce_s1) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && produce_s1) begin
			res_q.edge_level <= level;
			res_q.row_end <= last_col_s1;
			res_q.frame_end <= last_col_s1 && last_row_s1;
		end
	end

endmodule

>>> dv/tb_top.sv
module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 4;

	typedef enum logic [1:0] {STEP_PIXEL, STEP_WIDTH, STEP_HEIGHT} step_kind_t;
	typedef enum {TEX_NOISE, TEX_BINARY, TEX_FLAT} texture_t;

	typedef struct packed {
		step_kind_t           kind;
		logic [7:0]           value;
		logic                 frame_start;
		logic                 typed;
		sem_pkg::sem_result_t want;
	} step_t;

	localparam sem_pkg::sem_result_t NO_RESULT = '0;

	step_t directed_steps [25] = '{
		'{STEP_WIDTH,  8'h80, 1'b0, 1'b0, NO_RESULT},
		'{STEP_HEIGHT, 8'h00, 1'b0, 1'b0, NO_RESULT},
		'{STEP_PIXEL,  8'd0,   1'b1, 1'b0, NO_RESULT},
		'{STEP_PIXEL,  8'd0,   1'b0, 1'b0, NO_RESULT},
		'{STEP_PIXEL,  8'd255, 1'b0, 1'b0, NO_RESULT},
		'{STEP_PIXEL,  8'd0,   1'b0, 1'b0, NO_RESULT},
		'{STEP_PIXEL,  8'd128, 1'b0, 1'b0, NO_RESULT},
		'{STEP_PIXEL,  8'd255, 1'b0, 1'b0, NO_RESULT},
		'{STEP_PIXEL,  8'd255, 1'b0, 1'b0, NO_RESULT},
		'{STEP_PIXEL,  8'd255, 1'b0, 1'b0, NO_RESULT},
		'{STEP_PIXEL,  8'd255, 1'b0, 1'b1, '{4'd11, 1'b1, 1'b1}},
		'{STEP_WIDTH,  8'd5,   1'b0, 1'b0, NO_RESULT},
		'{STEP_PIXEL,  8'd10,  1'b0, 1'b0, NO_RESULT},
		'{STEP_PIXEL,  8'd200, 1'b0, 1'b0, NO_RESULT},
		'{STEP_PIXEL,  8'd30,  1'b0, 1'b0, NO_RESULT},
		'{STEP_PIXEL,  8'd180, 1'b0, 1'b0, NO_RESULT},
		'{STEP_PIXEL,  8'd50,  1'b0, 1'b0, NO_RESULT},
		'{STEP_PIXEL,  8'd90,  1'b0, 1'b0, NO_RESULT},
		'{STEP_PIXEL,  8'd90,  1'b0, 1'b0, NO_RESULT},
		'{STEP_PIXEL,  8'd90,  1'b0, 1'b0, NO_RESULT},
		'{STEP_PIXEL,  8'd90,  1'b0, 1'b0, NO_RESULT},
		'{STEP_WIDTH,  8'd3,   1'b0, 1'b0, NO_RESULT},
		'{STEP_PIXEL,  8'd40,  1'b0, 1'b0, NO_RESULT},
		'{STEP_PIXEL,  8'd40,  1'b0, 1'b0, NO_RESULT},
		'{STEP_PIXEL,  8'd40,  1'b0, 1'b0, NO_RESULT}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	sem_pkg::sem_pixel_t pix = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	sem_pkg::sem_result_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [sem_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [sem_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic [sem_pkg::COL_W-1:0] cfg_width = sem_pkg::WIDTH_RESET;
	logic [sem_pkg::ROW_W-1:0] cfg_height = sem_pkg::HEIGHT_RESET;
	logic [sem_pkg::PIXEL_W-1:0] upper_row [sem_pkg::DEF_MAX_WIDTH] = '{default: '0};
	logic [sem_pkg::PIXEL_W-1:0] middle_row [sem_pkg::DEF_MAX_WIDTH] = '{default: '0};
	logic [sem_pkg::PIXEL_W-1:0] window_px [6] = '{default: '0};
	int col_pos = 0;
	int row_pos = 0;

	sem_pkg::sem_result_t pending_edges [$];
	int mismatches = 0;
	int results_checked = 0;
	int pixels_sent = 0;
	int settings_written = 0;
	int cycle_count = 0;
	int stall_left = 0;
	bit idling_on = 1'b1;
	bit need_start = 1'b0;

	sobel_edge_magnitude_3x3 DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int frame_cols();
		if (cfg_width < sem_pkg::MIN_SIZE) return sem_pkg::MIN_SIZE;
		if (cfg_width > sem_pkg::DEF_MAX_WIDTH) return sem_pkg::DEF_MAX_WIDTH;
		return cfg_width;
	endfunction

	function automatic int frame_rows();
		if (cfg_height < sem_pkg::MIN_SIZE) return sem_pkg::MIN_SIZE;
		return cfg_height;
	endfunction

	function automatic int magnitude(input int v);
		return v < 0 ? -v : v;
	endfunction

	task automatic sobel_advance(input sem_pkg::sem_pixel_t p, output bit produced,
			output sem_pkg::sem_result_t edge_out);
		int w, h, a0, b0, c0, a1, c1, a2, b2, c2, gx, gy, mag;
		logic [sem_pkg::PIXEL_W-1:0] top, mid;
		w = frame_cols();
		h = frame_rows();
		if (p.frame_start) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h) row_pos = 0;
		top = upper_row[col_pos];
		mid = middle_row[col_pos];
		produced = (col_pos >= 2) && (row_pos >= 2);
		edge_out = NO_RESULT;
		if (produced) begin
			a0 = window_px[0];
			b0 = window_px[1];
			c0 = window_px[2];
			a1 = window_px[3];
			c1 = window_px[5];
			a2 = top;
			b2 = mid;
			c2 = p.pixel;
			gx = -a0 + a2 - 2 * b0 + 2 * b2 - c0 + c2;
			gy = -a0 - 2 * a1 - a2 + c0 + 2 * c1 + c2;
			mag = magnitude(gx) + magnitude(gy);
			edge_out.edge_level = sem_pkg::LEVEL_W'(mag >> sem_pkg::LEVEL_SHIFT);
			edge_out.row_end = (col_pos == w - 1);
			edge_out.frame_end = (col_pos == w - 1) && (row_pos == h - 1);
		end
		upper_row[col_pos] = mid;
		middle_row[col_pos] = p.pixel;
		window_px[0] = window_px[3];
		window_px[1] = window_px[4];
		window_px[2] = window_px[5];
		window_px[3] = top;
		window_px[4] = mid;
		window_px[5] = p.pixel;
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
	endtask

	task automatic send_pixel(input sem_pkg::sem_pixel_t p, input bit typed,
			input sem_pkg::sem_result_t want);
		bit produced;
		sem_pkg::sem_result_t predicted;
		if (idling_on && $urandom_range(0, 7) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		pix <= p;
		pix_valid <= 1'b1;
		do @(posedge clk); while (pix_stall);
		sobel_advance(p, produced, predicted);
		if (typed) pending_edges.push_back(want);
		else if (produced) pending_edges.push_back(predicted);
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [sem_pkg::CFG_INDEX_W-1:0] index,
			input logic [7:0] data);
		pix_valid <= 1'b0;
		while (pending_edges.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_index <= index;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (index == sem_pkg::REG_FRAME_WIDTH) cfg_width = data[sem_pkg::COL_W-1:0];
		else cfg_height = data;
		settings_written++;
		need_start = 1'b1;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic stream_frames(input int nframes);
		int w, h, base;
		texture_t texture;
		sem_pkg::sem_pixel_t p;
		w = frame_cols();
		h = frame_rows();
		for (int f = 0; f < nframes; f++) begin
			texture = texture_t'($urandom_range(0, 2));
			base = $urandom_range(0, 240);
			for (int i = 0; i < w * h; i++) begin
				case (texture)
					TEX_NOISE: p.pixel = 8'($urandom);
					TEX_BINARY: p.pixel = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					default: p.pixel = 8'(base + $urandom_range(0, 15));
				endcase
				if (i == 0) p.frame_start = need_start || ($urandom_range(0, 1) == 1);
				else p.frame_start = ($urandom_range(0, 59) == 0);
				need_start = 1'b0;
				send_pixel(p, 1'b0, NO_RESULT);
			end
		end
	endtask

	task automatic run_phase(input logic [7:0] width_data, input logic [7:0] height_data,
			input int nframes);
		write_reg(sem_pkg::REG_FRAME_WIDTH, width_data);
		write_reg(sem_pkg::REG_FRAME_HEIGHT, height_data);
		stream_frames(nframes);
	endtask

	always @(negedge clk) begin
		if (!arst_n || !idling_on) begin
			stall_left = 0;
			res_stall <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 18) - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		sem_pkg::sem_result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_edges.size() == 0) begin
				$error("unexpected transaction: edge_level %0d row_end %0d frame_end %0d",
					res.edge_level, res.row_end, res.frame_end);
				mismatches++;
			end else begin
				want = pending_edges.pop_front();
				results_checked++;
				if (res.edge_level !== want.edge_level) begin
					$error("edge_level: expected %0d, got %0d", want.edge_level, res.edge_level);
					mismatches++;
				end
				if (res.row_end !== want.row_end) begin
					$error("row_end: expected %0d, got %0d", want.row_end, res.row_end);
					mismatches++;
				end
				if (res.frame_end !== want.frame_end) begin
					$error("frame_end: expected %0d, got %0d", want.frame_end, res.frame_end);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$error("timeout with %0d results outstanding", pending_edges.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		sem_pkg::sem_pixel_t p;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_steps[i]) begin
			case (directed_steps[i].kind)
				STEP_WIDTH: write_reg(sem_pkg::REG_FRAME_WIDTH, directed_steps[i].value);
				STEP_HEIGHT: write_reg(sem_pkg::REG_FRAME_HEIGHT, directed_steps[i].value);
				default: begin
					p.pixel = directed_steps[i].value;
					p.frame_start = directed_steps[i].frame_start;
					send_pixel(p, directed_steps[i].typed, directed_steps[i].want);
				end
			endcase
		end

		while (pixels_sent < 200) begin
			idling_on = ($urandom_range(0, 3) != 0);
			run_phase({1'($urandom_range(0, 1)), 7'($urandom_range(0, 12))},
				8'($urandom_range(0, 8)), $urandom_range(1, 3));
		end
		idling_on = 1'b1;
		run_phase(8'hC8, 8'd3, 1);
		idling_on = 1'b0;
		run_phase(8'd3, 8'd40, 1);

		pix_valid <= 1'b0;
		while (pending_edges.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		$display("Streamed %0d pixels over %0d register writes, widths 3 to 64, heights 3 to 40.",
			pixels_sent, settings_written);
		$display("Compared %0d edge results, %0d field mismatches.", results_checked, mismatches);
		if (mismatches == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
